@@ hdl/assert_macros.svh @@
// Assertion macros shared by the motor stall detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define MSFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Same-cycle implication.
`define MSFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define MSFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MSFD_ASSERT(lbl, clk, rst, prop, msg)
`define MSFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MSFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/msfd_pkg.sv @@
// Shared types and constants for the motor stall and Hall fault detector.
`default_nettype none
package msfd_pkg;

   localparam int CurW  = 14;
   localparam int TimeW = 32;
   localparam int CsrIdxW = 3;

   // event codes
   localparam logic [1:0] EVT_PULSE       = 2'd0;
   localparam logic [1:0] EVT_FAULT_CHECK = 2'd1;
   localparam logic [1:0] EVT_STALL_CHECK = 2'd2;
   localparam logic [1:0] EVT_CLEAR_BLOCK = 2'd3;

   // register indexes
   localparam logic [CsrIdxW-1:0] REG_RUN_CURRENT_MIN      = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_RUN_CURRENT_MAX      = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_NO_PULSE_INTERVAL_US = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_STALL_CURRENT        = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_STALL_TIME_US        = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_FAULT_BLOCK_CURRENT  = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_FAULT_HOLD_MS        = 3'd6;

   // register reset values
   localparam logic [CurW-1:0]  RST_RUN_CURRENT_MIN      = 14'd100;
   localparam logic [CurW-1:0]  RST_RUN_CURRENT_MAX      = 14'd1500;
   localparam logic [TimeW-1:0] RST_NO_PULSE_INTERVAL_US = 32'd200000;
   localparam logic [CurW-1:0]  RST_STALL_CURRENT        = 14'd2100;
   localparam logic [TimeW-1:0] RST_STALL_TIME_US        = 32'd200000;
   localparam logic [CurW-1:0]  RST_FAULT_BLOCK_CURRENT  = 14'd1500;
   localparam logic [TimeW-1:0] RST_FAULT_HOLD_MS        = 32'd500;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [CurW-1:0]  current_ma;
      logic [TimeW-1:0] time_us;
      logic [TimeW-1:0] time_ms;
      logic             closing_cmd;
   } req_word_type;

   typedef struct packed {
      logic block_flag;
      logic homed;
      logic sensor_error;
      logic set_close_ref;
   } rsp_word_type;

   typedef struct packed {
      logic [CurW-1:0]  run_current_min;
      logic [CurW-1:0]  run_current_max;
      logic [TimeW-1:0] no_pulse_interval_us;
      logic [CurW-1:0]  stall_current;
      logic [TimeW-1:0] stall_time_us;
      logic [CurW-1:0]  fault_block_current;
      logic [TimeW-1:0] fault_hold_ms;
   } cfg_type;

endpackage
`default_nettype wire

@@ hdl/motor_stall_fault_detector_core.sv @@
// Top level: motor stall and Hall sensor fault detector with handshake stages.
// A request word accepted into the input register is evaluated by the supervisor
//   and its result is captured in the response register.
// Throughput: one word per cycle while the response channel is not stalled.
// Reset (synchronous, active high): both stages empty, supervisor state cleared,
//   configuration registers back to their defaults.
`default_nettype none
`include "assert_macros.svh"
module motor_stall_fault_detector_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire msfd_pkg::req_word_type       req_data,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output msfd_pkg::rsp_word_type            rsp_data,
   // configuration writes
   input  wire logic                         csr_we,
   input  wire logic [msfd_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [msfd_pkg::TimeW-1:0]   csr_wdata
);

   msfd_pkg::cfg_type      cfg;
   msfd_pkg::req_word_type in_word_ff;
   logic                   in_valid_ff, in_valid_in;
   msfd_pkg::rsp_word_type rsp_word_ff;
   msfd_pkg::rsp_word_type step_result;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   advance;   // input word moves through supervisor
   logic                   take_req;

   msfd_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   msfd_supervisor u_sup (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .word    (in_word_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // The response register frees up when empty or being drained this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   // Input register takes a new word whenever it is empty or moving on.
   assign req_ready = !in_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = take_req || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         rsp_word_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // a parked input word must not be overwritten
   `MSFD_ASSERT_NXT(a_in_hold, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_word_ff), "input word lost while stalled")
   // with both stages full and output stalled, no new word may enter
   `MSFD_ASSERT_IMP(a_full_blocks, clock, reset, in_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready, "request taken with pipeline full")
   // a close reference strobe only comes with the homed flag set
   `MSFD_ASSERT_IMP(a_strobe_homed, clock, reset, rsp_valid_ff && rsp_word_ff.set_close_ref, rsp_word_ff.homed && rsp_word_ff.block_flag, "strobe without homed")

endmodule
`default_nettype wire

@@ hdl/msfd_cfg_regs.sv @@
// Configuration register file for the motor stall and Hall fault detector.
`default_nettype none
module msfd_cfg_regs (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [msfd_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [msfd_pkg::TimeW-1:0]   csr_wdata,
   output msfd_pkg::cfg_type                 cfg
);

   msfd_pkg::cfg_type cfg_ff;
   msfd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            msfd_pkg::REG_RUN_CURRENT_MIN:
               cfg_in.run_current_min = csr_wdata[msfd_pkg::CurW-1:0];
            msfd_pkg::REG_RUN_CURRENT_MAX:
               cfg_in.run_current_max = csr_wdata[msfd_pkg::CurW-1:0];
            msfd_pkg::REG_NO_PULSE_INTERVAL_US:
               cfg_in.no_pulse_interval_us = csr_wdata;
            msfd_pkg::REG_STALL_CURRENT:
               cfg_in.stall_current = csr_wdata[msfd_pkg::CurW-1:0];
            msfd_pkg::REG_STALL_TIME_US:
               cfg_in.stall_time_us = csr_wdata;
            msfd_pkg::REG_FAULT_BLOCK_CURRENT:
               cfg_in.fault_block_current = csr_wdata[msfd_pkg::CurW-1:0];
            msfd_pkg::REG_FAULT_HOLD_MS:
               cfg_in.fault_hold_ms = csr_wdata;
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_current_min      <= msfd_pkg::RST_RUN_CURRENT_MIN;
         cfg_ff.run_current_max      <= msfd_pkg::RST_RUN_CURRENT_MAX;
         cfg_ff.no_pulse_interval_us <= msfd_pkg::RST_NO_PULSE_INTERVAL_US;
         cfg_ff.stall_current        <= msfd_pkg::RST_STALL_CURRENT;
         cfg_ff.stall_time_us        <= msfd_pkg::RST_STALL_TIME_US;
         cfg_ff.fault_block_current  <= msfd_pkg::RST_FAULT_BLOCK_CURRENT;
         cfg_ff.fault_hold_ms        <= msfd_pkg::RST_FAULT_HOLD_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ hdl/msfd_supervisor.sv @@
// Supervisor state and per-event update logic.
`default_nettype none
`include "assert_macros.svh"
module msfd_supervisor (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire msfd_pkg::req_word_type word,
   input  wire msfd_pkg::cfg_type      cfg,
   output msfd_pkg::rsp_word_type      result
);

   logic                       pulse_absent_ff,   pulse_absent_in;
   logic [msfd_pkg::TimeW-1:0] fault_start_us_ff, fault_start_us_in;
   logic                       sensor_fault_ff,   sensor_fault_in;
   logic                       stall_armed_ff,    stall_armed_in;
   logic [msfd_pkg::TimeW-1:0] stall_start_us_ff, stall_start_us_in;
   logic [msfd_pkg::TimeW-1:0] fault_ok_ms_ff,    fault_ok_ms_in;
   logic                       block_seen_ff,     block_seen_in;
   logic                       homed_ff,          homed_in;
   logic                       strobe;

   logic                       in_window;
   logic [msfd_pkg::TimeW-1:0] fault_elapsed;
   logic [msfd_pkg::TimeW-1:0] stall_elapsed;
   logic [msfd_pkg::TimeW-1:0] hold_elapsed;
   logic [msfd_pkg::TimeW-1:0] stall_base;

   always_comb begin
      in_window = (word.current_ma > cfg.run_current_min) &&
                  (word.current_ma < cfg.run_current_max);
      fault_elapsed = word.time_us - fault_start_us_ff;
      stall_base    = stall_armed_ff ? stall_start_us_ff : word.time_us;
      stall_elapsed = word.time_us - stall_base;
      hold_elapsed  = word.time_ms - fault_ok_ms_ff;
   end

   always_comb begin
      pulse_absent_in   = pulse_absent_ff;
      fault_start_us_in = fault_start_us_ff;
      sensor_fault_in   = sensor_fault_ff;
      stall_armed_in    = stall_armed_ff;
      stall_start_us_in = stall_start_us_ff;
      fault_ok_ms_in    = fault_ok_ms_ff;
      block_seen_in     = block_seen_ff;
      homed_in          = homed_ff;
      strobe            = 1'b0;
      case (word.req_type)
         msfd_pkg::EVT_PULSE: begin
            pulse_absent_in = 1'b0;
            stall_armed_in  = 1'b0;
         end
         msfd_pkg::EVT_FAULT_CHECK: begin
            if (in_window && pulse_absent_ff) begin
               if (fault_elapsed >= cfg.no_pulse_interval_us) begin
                  sensor_fault_in = 1'b1;
                  stall_armed_in  = 1'b0;
                  homed_in        = 1'b0;
               end else begin
                  sensor_fault_in = 1'b0;
               end
            end else begin
               if (!pulse_absent_ff) begin
                  sensor_fault_in = 1'b0;
               end
               fault_start_us_in = word.time_us;
            end
            pulse_absent_in = 1'b1;
         end
         msfd_pkg::EVT_STALL_CHECK: begin
            if (word.closing_cmd) begin
               stall_start_us_in = stall_base;
               stall_armed_in    = 1'b1;
               if (sensor_fault_ff) begin
                  if (word.current_ma > cfg.fault_block_current) begin
                     if (hold_elapsed > cfg.fault_hold_ms) begin
                        block_seen_in = 1'b1;
                     end
                  end else begin
                     stall_armed_in = 1'b0;
                     fault_ok_ms_in = word.time_ms;
                  end
               end else if (stall_elapsed >= cfg.stall_time_us &&
                            word.current_ma >= cfg.stall_current) begin
                  block_seen_in = 1'b1;
                  if (!homed_ff) begin
                     strobe   = 1'b1;
                     homed_in = 1'b1;
                  end
               end
            end
         end
         msfd_pkg::EVT_CLEAR_BLOCK: begin
            block_seen_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_comb begin
      result.block_flag    = block_seen_in;
      result.homed         = homed_in;
      result.sensor_error  = sensor_fault_in;
      result.set_close_ref = strobe;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_absent_ff   <= 1'b0;
         fault_start_us_ff <= '0;
         sensor_fault_ff   <= 1'b0;
         stall_armed_ff    <= 1'b0;
         stall_start_us_ff <= '0;
         fault_ok_ms_ff    <= '0;
         block_seen_ff     <= 1'b0;
         homed_ff          <= 1'b0;
      end else if (step_en) begin
         pulse_absent_ff   <= pulse_absent_in;
         fault_start_us_ff <= fault_start_us_in;
         sensor_fault_ff   <= sensor_fault_in;
         stall_armed_ff    <= stall_armed_in;
         stall_start_us_ff <= stall_start_us_in;
         fault_ok_ms_ff    <= fault_ok_ms_in;
         block_seen_ff     <= block_seen_in;
         homed_ff          <= homed_in;
      end
   end

   // a sensor fault always knocks out the position reference
   `MSFD_ASSERT_IMP(a_fault_drops_homed, clock, reset, $rose(sensor_fault_ff), !homed_ff, "homed survived sensor fault")
   // homing only happens on the healthy-sensor stall path
   `MSFD_ASSERT_IMP(a_strobe_no_fault, clock, reset, step_en && strobe, !sensor_fault_ff && homed_in && block_seen_in, "close ref strobe on wrong path")
   // state moves only on an evaluated word
   `MSFD_ASSERT_NXT(a_state_hold, clock, reset, !step_en, $stable(homed_ff) && $stable(sensor_fault_ff) && $stable(block_seen_ff), "state changed without a word")

endmodule
`default_nettype wire
